// ===== rtl/tof_range_frame_decoder_defines.svh =====
// Assertion macros used by the frame decoder.
`ifndef TOF_RANGE_FRAME_DECODER_DEFINES_SVH
`define TOF_RANGE_FRAME_DECODER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TRFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define TRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trfd_pkg.sv =====
`default_nettype none

package trfd_pkg;

    // Number of sensors whose history is kept.
    localparam int NUM_SENSORS = 16;
    localparam int SENSOR_AW   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    localparam int DIST_W = 24;
    localparam int VEL_W  = 25;
    localparam int ACC_W  = 30;
    localparam int HIST_W = DIST_W + VEL_W;

    // Frame header bytes and payload length.
    localparam logic [7:0] HDR0_BYTE   = 8'h57;
    localparam logic [7:0] HDR1_BYTE   = 8'h00;
    localparam logic [7:0] HDR2_BYTE   = 8'hFF;
    localparam logic [3:0] PAYLOAD_LEN = 4'd11;

    // Ids at or above this value have no history entry.
    localparam logic [8:0] ID_LIMIT = 9'(NUM_SENSORS);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_ID      = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        FS_GOOD   = 2'd0,
        FS_CSUM   = 2'd1,
        FS_BAD_ID = 2'd2
    } t_frame_status;

endpackage

`default_nettype wire

// ===== rtl/trfd_if.sv =====
`default_nettype none

// Byte request channel from the serial receiver.
interface trfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame request channel.
interface trfd_result_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    frame_status;
    logic [7:0]                    sensor_id;
    logic [31:0]                   sensor_time;
    logic signed [23:0]            distance_mm;
    logic [7:0]                    range_status;
    logic [15:0]                   strength;
    logic signed [24:0]            velocity_cm_s;
    logic signed [29:0]            accel_cm_s2;

    modport source (output valid, output frame_status, output sensor_id, output sensor_time,
                    output distance_mm, output range_status, output strength,
                    output velocity_cm_s, output accel_cm_s2, input ready);
    modport sink   (input valid, input frame_status, input sensor_id, input sensor_time,
                    input distance_mm, input range_status, input strength,
                    input velocity_cm_s, input accel_cm_s2, output ready);
endinterface

`default_nettype wire

// ===== rtl/trfd_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write port and one registered read port.
module trfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tof_range_frame_decoder.sv =====
// Range sensor frame decoder.
// The i_rx channel carries one serial byte per request. The block hunts for
// the 16-byte frame 0x57, 0x00, 0xFF, id, eleven payload bytes and a sum
// checksum; a byte that breaks the pattern drops the parser back to idle.
// The o_res channel carries one request per completed frame: status, id,
// timestamp, distance, range status, strength, velocity and acceleration.
// One byte is taken every cycle while i_rx.ready holds. The result appears
// on o_res in the cycle after the checksum byte is taken, from an output register.
// Per-sensor history sits in one RAM read when the id byte arrives and
// written back when a good frame ends; velocity and acceleration are
// built in stages while the last payload bytes arrive.
// Reset clears the parser and marks every history entry empty at once,
// so no clearing pass is needed and bytes are taken right after reset.
// While a result waits for o_res.ready, bytes other than a checksum byte
// are still taken; a checksum byte waits until the result register frees.
`default_nettype none

module tof_range_frame_decoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    trfd_byte_if.sink    i_rx,
    trfd_result_if.source o_res
);

    import trfd_pkg::*;
    `include "tof_range_frame_decoder_defines.svh"

    // Parser state.
    t_phase       r_phase, n_phase;
    logic [3:0]   r_left, n_left;
    logic         w_acc_rx;
    logic         w_id_byte;
    logic         w_pay_byte;
    logic         w_finish;
    logic [7:0]   w_b;

    // Frame fields collected on the fly.
    logic [7:0]   r_sum;
    logic [7:0]   r_id;
    logic         r_id_ok;
    logic         r_hist_valid;
    logic [31:0]  r_time;
    logic [23:0]  r_dist;
    logic [7:0]   r_rstat;
    logic [15:0]  r_str;

    // Motion pipeline.
    logic signed [VEL_W-1:0]  r_vel;
    logic signed [VEL_W:0]    r_vdiff;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_vd_ext;
    logic [DIST_W-1:0]        w_prior_d;
    logic [VEL_W-1:0]         w_prior_v;

    // History memory.
    logic [NUM_SENSORS-1:0]   r_valid;
    logic                     w_ram_we;
    logic                     w_ram_re;
    logic [SENSOR_AW-1:0]     w_raddr;
    logic [SENSOR_AW-1:0]     w_waddr;
    logic [HIST_W-1:0]        w_rdata;
    logic                     w_in_range;
    t_frame_status            w_status;

    // Output register.
    logic                     r_out_valid;
    t_frame_status            r_out_status;
    logic [7:0]               r_out_id;
    logic [31:0]              r_out_time;
    logic [23:0]              r_out_dist;
    logic [7:0]               r_out_rstat;
    logic [15:0]              r_out_str;
    logic [VEL_W-1:0]         r_out_vel;
    logic [ACC_W-1:0]         r_out_acc;

    assign w_b = i_rx.rx_byte;

    // Only the checksum byte needs the output register free.
    assign i_rx.ready = !r_out_valid || o_res.ready || (r_phase != PH_CHECK);
    assign w_acc_rx   = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        w_id_byte  = 1'b0;
        w_pay_byte = 1'b0;
        w_finish   = 1'b0;
        if (w_acc_rx) begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = (w_b == HDR0_BYTE) ? PH_HDR1 : PH_IDLE;
                end
                PH_HDR1: begin
                    n_phase = (w_b == HDR1_BYTE) ? PH_HDR2 : PH_IDLE;
                end
                PH_HDR2: begin
                    n_phase = (w_b == HDR2_BYTE) ? PH_ID : PH_IDLE;
                end
                PH_ID: begin
                    w_id_byte = 1'b1;
                    n_left    = PAYLOAD_LEN;
                    n_phase   = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (r_left != 4'd0) begin
                        w_pay_byte = 1'b1;
                        n_left     = r_left - 4'd1;
                        n_phase    = (r_left == 4'd1) ? PH_CHECK : PH_PAYLOAD;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CHECK: begin
                    w_finish = 1'b1;
                    n_phase  = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // The history entry is read as the id byte arrives and the read data
    // register then holds until the next id byte, well after write-back.
    assign w_in_range = ({1'b0, w_b} < ID_LIMIT);
    assign w_raddr    = w_b[SENSOR_AW-1:0];
    assign w_waddr    = r_id[SENSOR_AW-1:0];
    assign w_ram_re   = w_id_byte;

    assign w_prior_d = r_hist_valid ? w_rdata[DIST_W-1:0] : '0;
    assign w_prior_v = r_hist_valid ? w_rdata[HIST_W-1:DIST_W] : '0;

    // A checksum fault outranks an id beyond the table.
    always_comb begin
        if (r_sum != w_b) begin
            w_status = FS_CSUM;
        end else if (!r_id_ok) begin
            w_status = FS_BAD_ID;
        end else begin
            w_status = FS_GOOD;
        end
    end

    assign w_ram_we = w_finish && (w_status == FS_GOOD);
    assign w_vd_ext = ACC_W'(r_vdiff);

    trfd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_SENSORS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_vel, r_dist}),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Entry valid bits stand in for a cleared history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    // Frame fields, running checksum and the motion pipeline. Velocity is
    // formed once the distance is complete, then the velocity difference,
    // then times ten as a shift-and-add, one step per payload byte.
    always_ff @(posedge i_clk) begin
        if (w_acc_rx) begin
            r_sum <= (r_phase == PH_IDLE) ? w_b : r_sum + w_b;
        end
        if (w_id_byte) begin
            r_id         <= w_b;
            r_id_ok      <= w_in_range;
            r_hist_valid <= w_in_range && r_valid[w_raddr];
        end
        if (w_pay_byte) begin
            case (r_left)
                4'd11: r_time[7:0]   <= w_b;
                4'd10: r_time[15:8]  <= w_b;
                4'd9:  r_time[23:16] <= w_b;
                4'd8:  r_time[31:24] <= w_b;
                4'd7:  r_dist[7:0]   <= w_b;
                4'd6:  r_dist[15:8]  <= w_b;
                4'd5:  r_dist[23:16] <= w_b;
                4'd4: begin
                    r_rstat <= w_b;
                    r_vel   <= signed'({r_dist[23], r_dist}) -
                               signed'({w_prior_d[23], w_prior_d});
                end
                4'd3: begin
                    r_str[7:0] <= w_b;
                    r_vdiff    <= signed'({r_vel[VEL_W-1], r_vel}) -
                                  signed'({w_prior_v[VEL_W-1], w_prior_v});
                end
                4'd2: begin
                    r_str[15:8] <= w_b;
                    r_acc       <= (w_vd_ext <<< 3) + (w_vd_ext <<< 1);
                end
                default: begin
                    // The reserved byte only enters the checksum.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_status <= w_status;
            r_out_id     <= r_id;
            r_out_time   <= r_time;
            r_out_dist   <= r_dist;
            r_out_rstat  <= r_rstat;
            r_out_str    <= r_str;
            r_out_vel    <= (w_status == FS_GOOD) ? r_vel : '0;
            r_out_acc    <= (w_status == FS_GOOD) ? r_acc : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.frame_status  = r_out_status;
    assign o_res.sensor_id     = r_out_id;
    assign o_res.sensor_time   = r_out_time;
    assign o_res.distance_mm   = r_out_dist;
    assign o_res.range_status  = r_out_rstat;
    assign o_res.strength      = r_out_str;
    assign o_res.velocity_cm_s = r_out_vel;
    assign o_res.accel_cm_s2   = r_out_acc;

    `TRFD_ASSERT_SAME(a_fault_no_motion, r_out_valid && (r_out_status != FS_GOOD), (r_out_vel == '0) && (r_out_acc == '0), "faulty frame reports motion")
    `TRFD_ASSERT_NEXT(a_frame_gives_result, w_finish, r_out_valid, "completed frame gave no result")
    `TRFD_ASSERT_SAME(a_payload_count, r_phase == PH_PAYLOAD, (r_left >= 4'd1) && (r_left <= PAYLOAD_LEN), "payload count out of range")
    `TRFD_ASSERT_SAME(a_ram_port_split, w_ram_we, !w_ram_re, "history read and write in one cycle")

endmodule

`default_nettype wire
